// ===== hdl/sbte_pkg.sv =====
package sbte_pkg;

  // command codes of an input item
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  // transaction status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CSUM    = 2'd1,
    ST_IDMIS   = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  typedef enum logic {
    PH_IDLE = 1'b0,
    PH_WAIT = 1'b1
  } phase_e;

  // status reply parser steps
  typedef enum logic [2:0] {
    PS_HDR1 = 3'd0,
    PS_HDR2 = 3'd1,
    PS_ID   = 3'd2,
    PS_LEN  = 3'd3,
    PS_ERR  = 3'd4,
    PS_P1   = 3'd5,
    PS_P2   = 3'd6,
    PS_CSUM = 3'd7
  } parse_e;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [7:0] HDR_BYTE = 8'hFF;
  localparam logic [7:0] BCAST_ID = 8'hFE;
  localparam logic [7:0] LEN_BASE = 8'd2;

  // frame bytes ahead of the parameters: FF FF id length instruction
  localparam logic [3:0] FRAME_FIXED = 4'd5;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_ANSWER_WAIT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_LIMIT = 1'b1;

  localparam logic [15:0] WAIT_RST  = 16'd20;
  localparam logic [3:0]  RETRY_RST = 4'd3;

  // inverted sum over id, length, instruction and the parameter bytes sent
  function automatic logic [7:0] frame_csum(input logic [7:0]  id,
                                            input logic [7:0]  instr,
                                            input logic [7:0]  addr,
                                            input logic [15:0] arg,
                                            input logic [1:0]  cnt);
    logic [7:0] sum;
    sum = id + (LEN_BASE + {6'd0, cnt}) + instr;
    if (cnt > 2'd0) sum = sum + addr;
    if (cnt > 2'd1) sum = sum + arg[7:0];
    if (cnt > 2'd2) sum = sum + arg[15:8];
    return ~sum;
  endfunction

endpackage

// ===== hdl/sbte_in_if.sv =====
interface sbte_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  device_id;
  logic [7:0]  instruction;
  logic [7:0]  reg_address;
  logic [15:0] argument;
  logic [1:0]  param_count;
  logic [7:0]  rx_byte;

  modport source (
    output valid, cmd, device_id, instruction, reg_address, argument, param_count, rx_byte,
    input  ready
  );
  modport sink (
    input  valid, cmd, device_id, instruction, reg_address, argument, param_count, rx_byte,
    output ready
  );
endinterface

// ===== hdl/sbte_out_if.sv =====
interface sbte_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [1:0]  status;
  logic [15:0] read_value;
  logic [7:0]  device_error;

  modport source (
    output valid, kind, tx_byte, last, status, read_value, device_error,
    input  ready
  );
  modport sink (
    input  valid, kind, tx_byte, last, status, read_value, device_error,
    output ready
  );
endinterface

// ===== hdl/servo_bus_transaction_engine_unit.sv =====
// servo bus transaction engine, one half-duplex request/status exchange at a time
//
// in_i takes items of three kinds: a start request (id, instruction, up to three
// parameter bytes), a byte received from the bus, and a one millisecond tick.
// out_o gives result items: frame bytes to transmit (FF FF id len instr params
// checksum) and one finished item with status, read value and device error.
// the last result caused by an input item is flagged with last.
// the first result of an item shows in the cycle after it is accepted;
// its results then leave one per cycle while the receiver is ready
// (a start emits 6 + param_count bytes, plus one finished item on broadcast).
// a new item is taken in the same cycle that the last result of the previous
// one is taken, and at once whenever nothing is pending; items that cause no
// result leave nothing pending.
// a stalled receiver holds the current result and the input side waits.
// cfg_we_i writes answer_wait_ms (index 0) or retry_limit (index 1).
// reset: registers go to 20 ms and 3 retries, the engine goes idle with the
// parser hunting the first header byte and nothing pending on out_o.
module servo_bus_transaction_engine_unit
  import sbte_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  sbte_in_if.sink            in_i,
  sbte_out_if.source         out_o
);

  // configuration
  logic [15:0] wait_q;
  logic [3:0]  retry_q;

  // transaction state
  phase_e      phase_q, phase_d;
  parse_e      parse_q, parse_d;
  logic [3:0]  attempt_q, attempt_d;
  logic [15:0] elapsed_q, elapsed_d;

  // saved request
  logic [7:0]  sid_q, sid_d;
  logic [7:0]  sinstr_q, sinstr_d;
  logic [7:0]  saddr_q, saddr_d;
  logic [15:0] sarg_q, sarg_d;
  logic [1:0]  scnt_q, scnt_d;

  // reply fields: id, length, error, first and second parameter
  logic [7:0]  rid_q, rid_d;
  logic [7:0]  rlen_q, rlen_d;
  logic [7:0]  rerr_q, rerr_d;
  logic [7:0]  rp1_q, rp1_d;
  logic [7:0]  rp2_q, rp2_d;

  // result job: optional frame, then optional finished item
  logic        frame_q, frame_d;
  logic        fin_q, fin_d;
  status_e     fin_st_q, fin_st_d;
  logic [15:0] fin_val_q, fin_val_d;
  logic [7:0]  fin_err_q, fin_err_d;
  logic [7:0]  csum_q, csum_d;
  logic [3:0]  idx_q, idx_d;

  logic        in_acc, out_acc;
  logic        frame_end, out_last;
  logic [7:0]  frame_byte;
  logic [7:0]  frame_len;
  logic [7:0]  reply_sum;
  logic        do_fail, do_send;
  status_e     fail_st;

  // ---------------------------------------------------------------------------
  // output side: walk the frame bytes, then the finished item
  // ---------------------------------------------------------------------------
  assign frame_len = LEN_BASE + {6'd0, scnt_q};
  assign frame_end = (idx_q == FRAME_FIXED + {2'd0, scnt_q});
  assign out_last  = frame_q ? (frame_end && !fin_q) : 1'b1;

  always_comb begin
    case (idx_q)
      4'd0, 4'd1: frame_byte = HDR_BYTE;
      4'd2:       frame_byte = sid_q;
      4'd3:       frame_byte = frame_len;
      4'd4:       frame_byte = sinstr_q;
      4'd5:       frame_byte = (scnt_q > 2'd0) ? saddr_q : csum_q;
      4'd6:       frame_byte = (scnt_q > 2'd1) ? sarg_q[7:0] : csum_q;
      4'd7:       frame_byte = (scnt_q > 2'd2) ? sarg_q[15:8] : csum_q;
      default:    frame_byte = csum_q;
    endcase
  end

  assign out_o.valid        = frame_q | fin_q;
  assign out_o.kind         = frame_q ? KIND_BYTE : KIND_DONE;
  assign out_o.tx_byte      = frame_q ? frame_byte : 8'd0;
  assign out_o.last         = out_last;
  assign out_o.status       = frame_q ? ST_OK : fin_st_q;
  assign out_o.read_value   = frame_q ? 16'd0 : fin_val_q;
  assign out_o.device_error = frame_q ? 8'd0 : fin_err_q;

  // take a new item when idle or when the last pending result leaves now
  assign in_i.ready = !(frame_q | fin_q) | (out_o.ready & out_last);
  assign in_acc     = in_i.valid & in_i.ready;
  assign out_acc    = out_o.valid & out_o.ready;

  // reply checksum over the five captured fields
  assign reply_sum = ~(rid_q + rlen_q + rerr_q + rp1_q + rp2_q);

  // ---------------------------------------------------------------------------
  // item processing: next state and the job it leaves behind
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_d   = phase_q;
    parse_d   = parse_q;
    attempt_d = attempt_q;
    elapsed_d = elapsed_q;
    sid_d     = sid_q;
    sinstr_d  = sinstr_q;
    saddr_d   = saddr_q;
    sarg_d    = sarg_q;
    scnt_d    = scnt_q;
    rid_d     = rid_q;
    rlen_d    = rlen_q;
    rerr_d    = rerr_q;
    rp1_d     = rp1_q;
    rp2_d     = rp2_q;
    frame_d   = frame_q;
    fin_d     = fin_q;
    fin_st_d  = fin_st_q;
    fin_val_d = fin_val_q;
    fin_err_d = fin_err_q;
    idx_d     = idx_q;
    do_fail   = 1'b0;
    do_send   = 1'b0;
    fail_st   = ST_OK;

    // advance through the pending job
    if (out_acc) begin
      if (frame_q) begin
        if (frame_end) begin
          frame_d = 1'b0;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end else begin
        fin_d = 1'b0;
      end
    end

    if (in_acc) begin
      // a fresh job replaces the finished one
      frame_d   = 1'b0;
      fin_d     = 1'b0;
      idx_d     = 4'd0;
      fin_st_d  = ST_OK;
      fin_val_d = 16'd0;
      fin_err_d = 8'd0;

      unique case (cmd_e'(in_i.cmd))
        CMD_START: begin
          if (phase_q == PH_IDLE) begin
            sid_d     = in_i.device_id;
            sinstr_d  = in_i.instruction;
            saddr_d   = in_i.reg_address;
            sarg_d    = in_i.argument;
            scnt_d    = in_i.param_count;
            attempt_d = 4'd0;
            do_send   = 1'b1;
            if (in_i.device_id == BCAST_ID) begin
              // broadcast: no reply expected
              fin_d = 1'b1;
            end else begin
              phase_d = PH_WAIT;
            end
          end
        end
        CMD_BYTE: begin
          if (phase_q == PH_WAIT) begin
            unique case (parse_q)
              PS_HDR1: if (in_i.rx_byte == HDR_BYTE) parse_d = PS_HDR2;
              PS_HDR2: parse_d = (in_i.rx_byte == HDR_BYTE) ? PS_ID : PS_HDR1;
              PS_ID: begin
                rid_d   = in_i.rx_byte;
                parse_d = PS_LEN;
              end
              PS_LEN: begin
                rlen_d  = in_i.rx_byte;
                parse_d = PS_ERR;
              end
              PS_ERR: begin
                rerr_d  = in_i.rx_byte;
                parse_d = (rlen_q > 8'd2) ? PS_P1 : PS_CSUM;
              end
              PS_P1: begin
                rp1_d   = in_i.rx_byte;
                parse_d = (rlen_q > 8'd3) ? PS_P2 : PS_CSUM;
              end
              PS_P2: begin
                rp2_d   = in_i.rx_byte;
                parse_d = PS_CSUM;
              end
              default: begin
                if (reply_sum != in_i.rx_byte) begin
                  do_fail = 1'b1;
                  fail_st = ST_CSUM;
                end else if (rid_q != sid_q) begin
                  do_fail = 1'b1;
                  fail_st = ST_IDMIS;
                end else begin
                  fin_d     = 1'b1;
                  fin_val_d = {rp2_q, rp1_q};
                  fin_err_d = rerr_q;
                  phase_d   = PH_IDLE;
                  parse_d   = PS_HDR1;
                end
              end
            endcase
          end
        end
        CMD_TICK: begin
          if (phase_q == PH_WAIT) begin
            if (elapsed_q >= wait_q) begin
              do_fail = 1'b1;
              fail_st = ST_TIMEOUT;
            end else begin
              elapsed_d = elapsed_q + 16'd1;
            end
          end
        end
        default: ; // unused command code is dropped
      endcase

      // failed attempt: resend while retries remain, else report
      if (do_fail) begin
        if (attempt_q < retry_q) begin
          attempt_d = attempt_q + 4'd1;
          do_send   = 1'b1;
        end else begin
          fin_d    = 1'b1;
          fin_st_d = fail_st;
          phase_d  = PH_IDLE;
          parse_d  = PS_HDR1;
        end
      end

      // a sent frame restarts the reply parser and the tick count
      if (do_send) begin
        frame_d   = 1'b1;
        parse_d   = PS_HDR1;
        elapsed_d = 16'd0;
        rid_d     = 8'd0;
        rlen_d    = 8'd0;
        rerr_d    = 8'd0;
        rp1_d     = 8'd0;
        rp2_d     = 8'd0;
      end
    end
  end

  // checksum of the frame that goes out, from the request it carries
  assign csum_d = frame_csum(sid_d, sinstr_d, saddr_d, sarg_d, scnt_d);

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q  <= WAIT_RST;
      retry_q <= RETRY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ANSWER_WAIT: wait_q  <= cfg_data_i;
        CFG_RETRY_LIMIT: retry_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      parse_q   <= PS_HDR1;
      attempt_q <= 4'd0;
      elapsed_q <= 16'd0;
      sid_q     <= 8'd0;
      sinstr_q  <= 8'd0;
      saddr_q   <= 8'd0;
      sarg_q    <= 16'd0;
      scnt_q    <= 2'd0;
      rid_q     <= 8'd0;
      rlen_q    <= 8'd0;
      rerr_q    <= 8'd0;
      rp1_q     <= 8'd0;
      rp2_q     <= 8'd0;
      frame_q   <= 1'b0;
      fin_q     <= 1'b0;
      idx_q     <= 4'd0;
    end else begin
      phase_q   <= phase_d;
      parse_q   <= parse_d;
      attempt_q <= attempt_d;
      elapsed_q <= elapsed_d;
      sid_q     <= sid_d;
      sinstr_q  <= sinstr_d;
      saddr_q   <= saddr_d;
      sarg_q    <= sarg_d;
      scnt_q    <= scnt_d;
      rid_q     <= rid_d;
      rlen_q    <= rlen_d;
      rerr_q    <= rerr_d;
      rp1_q     <= rp1_d;
      rp2_q     <= rp2_d;
      frame_q   <= frame_d;
      fin_q     <= fin_d;
      idx_q     <= idx_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    fin_st_q  <= fin_st_d;
    fin_val_q <= fin_val_d;
    fin_err_q <= fin_err_d;
    if (in_acc) csum_q <= csum_d;
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_idle_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> parse_q == PS_HDR1)
    else $error("engine idle while the reply parser is mid-frame");

  a_start_sends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.cmd == CMD_START && phase_q == PH_IDLE |=> frame_q && idx_q == 4'd0)
    else $error("start request did not begin a frame");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_q |-> idx_q <= FRAME_FIXED + {2'd0, scnt_q})
    else $error("frame byte index past the checksum");

  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_last |=> out_o.valid)
    else $error("results of one item were cut short");

endmodule

// ===== sim/tb_servo_bus_transaction_engine_unit.sv =====
`timescale 1ns / 100ps

module tb_servo_bus_transaction_engine_unit;
  import sbte_pkg::*;

  // cycle budget for the whole run, far above the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 400000;
  // quiet cycles before a register write and at the end of the run
  localparam int unsigned SETTLE_CYCLES = 12;
  // the command code that the engine never acts on
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // one input item as it crosses in_i
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  device_id;
    logic [7:0]  instruction;
    logic [7:0]  reg_address;
    logic [15:0] argument;
    logic [1:0]  param_count;
    logic [7:0]  rx_byte;
  } bus_item_t;

  // one result item as it leaves on out_o
  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [1:0]  status;
    logic [15:0] read_value;
    logic [7:0]  device_error;
  } bus_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [15:0]        cfg_data_i;

  sbte_in_if  in_bus ();
  sbte_out_if out_bus ();

  servo_bus_transaction_engine_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  always #1 clk_i = ~clk_i;

  // idle percentages of the two sides, changed between phases
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;

  int unsigned mismatch_count;
  // items the engine acted on, ignored ones excluded
  int unsigned live_items;

  // ---------------------------------------------------------------------------
  // transaction engine predictor: registers, engine state, expected results
  // ---------------------------------------------------------------------------
  logic [15:0] wait_limit_ms;
  logic [3:0]  retry_max;

  phase_e      eng_phase;
  parse_e      reply_step;
  logic [3:0]  attempt_no;
  logic [15:0] ticks_seen;
  logic [7:0]  req_id;
  logic [7:0]  req_instr;
  logic [7:0]  req_addr;
  logic [15:0] req_arg;
  logic [1:0]  req_count;
  // fields of the status reply collected so far
  logic [7:0]  reply_id;
  logic [7:0]  reply_len;
  logic [7:0]  reply_err;
  logic [7:0]  reply_p1;
  logic [7:0]  reply_p2;

  bus_result_t step_results[$];
  bus_result_t expected_bus_results[$];

  function automatic void reset_engine_model();
    wait_limit_ms = WAIT_RST;
    retry_max     = RETRY_RST;
    eng_phase     = PH_IDLE;
    reply_step    = PS_HDR1;
    attempt_no    = '0;
    ticks_seen    = '0;
    req_id        = '0;
    req_instr     = '0;
    req_addr      = '0;
    req_arg       = '0;
    req_count     = '0;
    reply_id      = '0;
    reply_len     = '0;
    reply_err     = '0;
    reply_p1      = '0;
    reply_p2      = '0;
    expected_bus_results.delete();
  endfunction

  function automatic void push_tx_byte(input logic [7:0] b);
    bus_result_t r;
    r = '0;
    r.kind = KIND_BYTE;
    r.tx_byte = b;
    step_results.push_back(r);
  endfunction

  // finished item; the engine drops back to idle
  function automatic void push_done(input status_e st, input logic [15:0] val,
                                    input logic [7:0] err);
    bus_result_t r;
    r = '0;
    r.kind = KIND_DONE;
    r.status = st;
    r.read_value = val;
    r.device_error = err;
    step_results.push_back(r);
    eng_phase  = PH_IDLE;
    reply_step = PS_HDR1;
  endfunction

  // whole request frame; checksum covers id, length, instruction and only the parameter bytes sent
  function automatic void emit_frame();
    logic [7:0] len;
    logic [7:0] sum;
    len = LEN_BASE + {6'd0, req_count};
    sum = req_id + len + req_instr;
    push_tx_byte(HDR_BYTE);
    push_tx_byte(HDR_BYTE);
    push_tx_byte(req_id);
    push_tx_byte(len);
    push_tx_byte(req_instr);
    if (req_count > 2'd0) begin
      push_tx_byte(req_addr);
      sum = sum + req_addr;
    end
    if (req_count > 2'd1) begin
      push_tx_byte(req_arg[7:0]);
      sum = sum + req_arg[7:0];
    end
    if (req_count > 2'd2) begin
      push_tx_byte(req_arg[15:8]);
      sum = sum + req_arg[15:8];
    end
    push_tx_byte(~sum);
    // a fresh attempt hunts the header again and restarts the tick count
    reply_step = PS_HDR1;
    ticks_seen = '0;
    reply_id   = '0;
    reply_len  = '0;
    reply_err  = '0;
    reply_p1   = '0;
    reply_p2   = '0;
  endfunction

  function automatic void retry_or_end(input status_e st);
    if (attempt_no < retry_max) begin
      attempt_no = attempt_no + 4'd1;
      emit_frame();
    end else begin
      push_done(st, 16'd0, 8'd0);
    end
  endfunction

  function automatic void take_reply_byte(input logic [7:0] b);
    logic [7:0] sum;
    case (reply_step)
      PS_HDR1: if (b == HDR_BYTE) reply_step = PS_HDR2;
      PS_HDR2: reply_step = (b == HDR_BYTE) ? PS_ID : PS_HDR1;
      PS_ID: begin
        reply_id   = b;
        reply_step = PS_LEN;
      end
      PS_LEN: begin
        reply_len  = b;
        reply_step = PS_ERR;
      end
      PS_ERR: begin
        reply_err  = b;
        reply_step = (reply_len > 8'd2) ? PS_P1 : PS_CSUM;
      end
      PS_P1: begin
        reply_p1   = b;
        reply_step = (reply_len > 8'd3) ? PS_P2 : PS_CSUM;
      end
      PS_P2: begin
        reply_p2   = b;
        reply_step = PS_CSUM;
      end
      default: begin
        sum = reply_id + reply_len + reply_err + reply_p1 + reply_p2;
        sum = ~sum;
        if (sum != b) retry_or_end(ST_CSUM);
        else if (reply_id != req_id) retry_or_end(ST_IDMIS);
        else push_done(ST_OK, {reply_p2, reply_p1}, reply_err);
      end
    endcase
  endfunction

  // advances the predictor by one accepted item, returns 1 if it was acted on
  function automatic bit predict_bus_item(input bus_item_t it);
    bit took;
    took = 1'b0;
    step_results.delete();
    case (it.cmd)
      CMD_START: if (eng_phase == PH_IDLE) begin
        took       = 1'b1;
        req_id     = it.device_id;
        req_instr  = it.instruction;
        req_addr   = it.reg_address;
        req_arg    = it.argument;
        req_count  = it.param_count;
        attempt_no = '0;
        emit_frame();
        if (req_id == BCAST_ID) push_done(ST_OK, 16'd0, 8'd0);
        else eng_phase = PH_WAIT;
      end
      CMD_BYTE: if (eng_phase == PH_WAIT) begin
        took = 1'b1;
        take_reply_byte(it.rx_byte);
      end
      CMD_TICK: if (eng_phase == PH_WAIT) begin
        took = 1'b1;
        if (ticks_seen >= wait_limit_ms) retry_or_end(ST_TIMEOUT);
        else ticks_seen = ticks_seen + 16'd1;
      end
      default: ;
    endcase
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) expected_bus_results.push_back(step_results[i]);
    return took;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  function automatic void report_mismatch(input string what, input bus_result_t want,
                                          input bus_result_t got);
    if (mismatch_count < 10) begin
      $display("%0t %s: want kind=%0d byte=%h last=%0d st=%0d val=%h err=%h",
               $time, what, want.kind, want.tx_byte, want.last, want.status,
               want.read_value, want.device_error);
      $display("%0t %s:  got kind=%0d byte=%h last=%0d st=%0d val=%h err=%h",
               $time, what, got.kind, got.tx_byte, got.last, got.status,
               got.read_value, got.device_error);
    end
    mismatch_count++;
  endfunction

  function automatic void check_bus_result(input bus_result_t got);
    bus_result_t want;
    if (expected_bus_results.size() == 0) begin
      report_mismatch("result with nothing expected", '0, got);
      return;
    end
    want = expected_bus_results.pop_front();
    if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
        got.last !== want.last || got.status !== want.status ||
        got.read_value !== want.read_value || got.device_error !== want.device_error)
      report_mismatch("result mismatch", want, got);
  endfunction

  // both handshakes are sampled at the rising edge; prediction runs first so
  // an item and its own result in one edge would still line up
  always @(posedge clk_i) begin
    bus_item_t   seen;
    bus_result_t got;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        seen.cmd         = in_bus.cmd;
        seen.device_id   = in_bus.device_id;
        seen.instruction = in_bus.instruction;
        seen.reg_address = in_bus.reg_address;
        seen.argument    = in_bus.argument;
        seen.param_count = in_bus.param_count;
        seen.rx_byte     = in_bus.rx_byte;
        if (predict_bus_item(seen)) live_items++;
      end
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.kind, out_bus.tx_byte, out_bus.last, out_bus.status,
               out_bus.read_value, out_bus.device_error};
        check_bus_result(got);
      end
    end
  end

  // receiver stalls at random, new decision every falling edge
  always @(negedge clk_i) out_bus.ready <= ($urandom_range(99) >= sink_idle_pct);

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("** servo_bus_transaction_engine_unit: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers; every task starts and ends on a falling edge
  // ---------------------------------------------------------------------------

  // drives one item, with random gaps ahead of it, and waits for acceptance;
  // valid stays high on return so a following item goes out back to back
  task automatic send_item(input bus_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.cmd         <= it.cmd;
    in_bus.device_id   <= it.device_id;
    in_bus.instruction <= it.instruction;
    in_bus.reg_address <= it.reg_address;
    in_bus.argument    <= it.argument;
    in_bus.param_count <= it.param_count;
    in_bus.rx_byte     <= it.rx_byte;
    do @(posedge clk_i); while (!in_bus.ready);
    @(negedge clk_i);
  endtask

  // random content in the fields that the command does not use
  function automatic bus_item_t junk_item(input logic [1:0] cmd);
    bus_item_t it;
    it.cmd         = cmd;
    it.device_id   = 8'($urandom);
    it.instruction = 8'($urandom);
    it.reg_address = 8'($urandom);
    it.argument    = 16'($urandom);
    it.param_count = 2'($urandom);
    it.rx_byte     = 8'($urandom);
    return it;
  endfunction

  task automatic send_start(input logic [7:0] id, input logic [7:0] instr,
                            input logic [7:0] addr, input logic [15:0] arg,
                            input logic [1:0] cnt);
    bus_item_t it;
    it = junk_item(CMD_START);
    it.device_id   = id;
    it.instruction = instr;
    it.reg_address = addr;
    it.argument    = arg;
    it.param_count = cnt;
    send_item(it);
  endtask

  task automatic send_byte(input logic [7:0] b);
    bus_item_t it;
    it = junk_item(CMD_BYTE);
    it.rx_byte = b;
    send_item(it);
  endtask

  task automatic send_tick();
    send_item(junk_item(CMD_TICK));
  endtask

  // status reply: FF FF id len err, parameters as len asks, checksum
  task automatic send_reply(input logic [7:0] rid, input logic [7:0] rlen,
                            input logic [7:0] rerr, input logic [15:0] rval,
                            input bit csum_ok);
    logic [7:0] sum;
    sum = rid + rlen + rerr;
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(rid);
    send_byte(rlen);
    send_byte(rerr);
    if (rlen > 8'd2) begin
      send_byte(rval[7:0]);
      sum = sum + rval[7:0];
    end
    if (rlen > 8'd3) begin
      send_byte(rval[15:8]);
      sum = sum + rval[15:8];
    end
    sum = ~sum;
    if (!csum_ok) sum = sum ^ 8'($urandom_range(255, 1));
    send_byte(sum);
  endtask

  // sender holds off until every expected result is out, then lets the
  // engine settle
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (expected_bus_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_ANSWER_WAIT) wait_limit_ms = data;
    else retry_max = data[3:0];
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // bytes, ticks and the unused code while idle do nothing; a broadcast with
  // every other field at its top sends the frame and finishes at once
  task automatic test_idle_items_and_broadcast();
    send_byte(HDR_BYTE);
    send_tick();
    send_item(junk_item(CMD_UNUSED));
    send_start(BCAST_ID, 8'hFF, 8'hFF, 16'hFFFF, 2'd3);
  endtask

  // header hunt, checksum error and id mismatch with resends, then a long
  // reply that carries value and device error; default registers
  task automatic test_reply_parsing();
    send_start(8'h00, 8'h00, 8'h00, 16'h0000, 2'd0);
    send_start(8'h33, 8'h02, 8'h10, 16'h0102, 2'd3);   // busy, ignored
    send_byte(8'h00);                                    // dropped while hunting
    send_byte(HDR_BYTE);
    send_byte(8'h12);                                    // breaks the header
    send_reply(8'h00, 8'd2, 8'h00, 16'h0000, 1'b0);
    send_reply(8'h55, 8'd2, 8'h00, 16'h0000, 1'b1);
    send_reply(8'h00, 8'd5, 8'hFF, 16'h1234, 1'b1);
  endtask

  // zero wait, register changes while a reply is awaited, retries used up
  task automatic test_timeouts();
    write_register(CFG_ANSWER_WAIT, 16'd0);
    write_register(CFG_RETRY_LIMIT, 16'd0);
    send_start(8'h01, 8'h01, 8'h2B, 16'h0000, 2'd1);
    send_tick();
    write_register(CFG_ANSWER_WAIT, 16'hFFFF);
    write_register(CFG_RETRY_LIMIT, 16'd15);
    send_start(8'hFD, 8'h03, 8'h1E, 16'h8001, 2'd2);
    send_tick();
    send_tick();
    // shorter wait lands while the engine is waiting for the reply
    write_register(CFG_ANSWER_WAIT, 16'd1);
    send_tick();
    write_register(CFG_RETRY_LIMIT, 16'd0);
    send_tick();
    send_tick();
  endtask

  // one request and whatever it takes to close it: mostly replies, some
  // broken, with noise, ticks and ignored items mixed in
  task automatic run_random_transaction();
    logic [7:0]  id;
    logic [7:0]  rlen;
    logic [7:0]  rid;
    int unsigned pick;
    int          actions;
    int          ticks_left;
    case ($urandom_range(19))
      0, 1:    id = BCAST_ID;
      2:       id = 8'h00;
      3:       id = 8'hFD;
      default: id = 8'($urandom_range(253));
    endcase
    send_start(id, 8'($urandom), 8'($urandom), 16'($urandom), 2'($urandom));
    actions = 0;
    while (eng_phase == PH_WAIT) begin
      pick = $urandom_range(99);
      if (actions > 30 || pick < 55) begin
        // late in a long exchange only clean replies go out so it closes
        rlen = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(5, 2));
        rid  = (actions <= 30 && $urandom_range(99) < 15) ?
               req_id ^ 8'($urandom_range(255, 1)) : req_id;
        send_reply(rid, rlen, 8'($urandom), 16'($urandom),
                   actions > 30 || $urandom_range(99) >= 15);
      end else if (pick < 70) begin
        send_byte($urandom_range(1) ? HDR_BYTE : 8'($urandom));
      end else if (pick < 80 && wait_limit_ms <= 16'd64) begin
        // run the attempt out to its timeout
        ticks_left = int'(wait_limit_ms) - int'(ticks_seen) + 1;
        repeat (ticks_left) send_tick();
      end else if (pick < 90) begin
        send_tick();
      end else if (pick < 95) begin
        send_item(junk_item(CMD_START));     // busy, ignored
      end else begin
        send_item(junk_item(CMD_UNUSED));
      end
      actions++;
    end
    // now and then an item that the idle engine ignores
    if ($urandom_range(9) == 0) send_item(junk_item($urandom_range(1) ? CMD_BYTE : CMD_TICK));
  endtask

  task automatic run_random_phase(input int unsigned target);
    int unsigned start_count;
    start_count = live_items;
    while (live_items - start_count < target) run_random_transaction();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_bus.valid       = 1'b0;
    in_bus.cmd         = CMD_START;
    in_bus.device_id   = '0;
    in_bus.instruction = '0;
    in_bus.reg_address = '0;
    in_bus.argument    = '0;
    in_bus.param_count = '0;
    in_bus.rx_byte     = '0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_ANSWER_WAIT;
    cfg_data_i         = '0;
    rst_ni             = 1'b0;
    mismatch_count     = 0;
    live_items         = 0;
    src_idle_pct       = 9;
    sink_idle_pct      = 68;
    reset_engine_model();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, the first two tests on the reset registers
    test_idle_items_and_broadcast();
    test_reply_parsing();
    test_timeouts();

    // sender rarely idles, receiver often stalls
    write_register(CFG_ANSWER_WAIT, 16'd3);
    write_register(CFG_RETRY_LIMIT, 16'd2);
    run_random_phase(100);

    // the other way round, a wait of 1 ms and most retries
    src_idle_pct  = 68;
    sink_idle_pct = 9;
    write_register(CFG_ANSWER_WAIT, 16'd1);
    write_register(CFG_RETRY_LIMIT, 16'd15);
    run_random_phase(100);

    // no idling, longest wait and no retries
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_register(CFG_ANSWER_WAIT, 16'hFFFF);
    write_register(CFG_RETRY_LIMIT, 16'd0);
    run_random_phase(50);

    write_register(CFG_ANSWER_WAIT, 16'($urandom_range(8, 2)));
    write_register(CFG_RETRY_LIMIT, 16'($urandom_range(4, 1)));
    run_random_phase(50);

    drain_results();
    if (mismatch_count == 0) begin
      $display("** servo_bus_transaction_engine_unit: PASSED **");
    end else begin
      $display("** servo_bus_transaction_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule
